// File: design/ptst_pkg.sv
// Shared types, widths and codes for the periodic task scheduler table.
// No dependencies; used by ptst_cell and periodic_task_scheduler_table_top.
package ptst_pkg;

	localparam int MAX_TASKS    = 32;
	localparam int TIME_W       = 32;
	localparam int AMT_W        = 32;
	localparam int SCALE_W      = 16;
	localparam int OP_W         = 3;
	localparam int TID_W        = 5;
	localparam int STATUS_W     = 3;
	localparam int RESULT_LIMIT = 32;
	localparam int IDX_W        = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CMP_W        = (IDX_W > TID_W) ? IDX_W : TID_W;
	localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

	localparam logic [OP_W-1:0] OP_ADD_PER = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD_AT  = 3'd1;
	localparam logic [OP_W-1:0] OP_DELETE  = 3'd2;
	localparam logic [OP_W-1:0] OP_CHG_PER = 3'd3;
	localparam logic [OP_W-1:0] OP_TICK    = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DUE       = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NONE_DUE  = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [TID_W-1:0] task_id;
		logic [AMT_W-1:0] amount;
	} req_t;

	typedef struct packed {
		logic [TID_W-1:0]    task_id_res;
		logic [STATUS_W-1:0] status;
		logic                last;
	} res_t;

	// request token walking down the cell chain
	typedef struct packed {
		logic              vld;
		logic [OP_W-1:0]   op;
		logic [TID_W-1:0]  id;
		logic [TIME_W-1:0] amt;   // scaled amount
		logic              hit;   // slot taken / addressed slot found
		logic [IDX_W-1:0]  slot;  // slot taken by an add
	} tok_t;

endpackage

// File: design/ptst_cell.sv
// One task slot of the scheduler chain plus the token register toward the next cell.
// Depends on ptst_pkg.
module ptst_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic [ptst_pkg::IDX_W-1:0] idx,
	input  ptst_pkg::tok_t             tok_in,
	output ptst_pkg::tok_t             tok_out,
	output logic                       due
);
	import ptst_pkg::*;

	logic              valid_q;
	logic [TIME_W-1:0] period_q;
	logic [TIME_W-1:0] next_due_q;
	logic              vld_q;
	tok_t              tok_q;
	tok_t              tok_nx;
	logic              id_match;

	assign id_match = (CMP_W'(tok_in.id) == CMP_W'(idx));
	assign due      = tok_in.vld && (tok_in.op == OP_TICK) && valid_q
		&& (tok_in.amt >= next_due_q);

	// token valid comes from the reset register, payload from the plain one
	always_comb begin
		tok_out     = tok_q;
		tok_out.vld = vld_q;
	end

	always_comb begin
		tok_nx = tok_in;
		case (tok_in.op)
			OP_ADD_PER, OP_ADD_AT: begin
				if (!tok_in.hit && !valid_q) begin
					tok_nx.hit  = 1'b1;
					tok_nx.slot = idx;
				end
			end
			OP_DELETE, OP_CHG_PER: begin
				if (id_match && valid_q)
					tok_nx.hit = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			vld_q   <= 1'b0;
		end else if (adv) begin
			vld_q <= tok_nx.vld;
			if (tok_in.vld) begin
				case (tok_in.op)
					OP_ADD_PER: begin
						if (!tok_in.hit && !valid_q) valid_q <= 1'b1;
					end
					OP_ADD_AT: begin
						if (!tok_in.hit && !valid_q) valid_q <= 1'b1;
					end
					OP_DELETE: begin
						if (id_match && valid_q) valid_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	// slot payload and token payload, no reset
	always_ff @(posedge clk) begin
		if (adv) begin
			tok_q <= tok_nx;
			if (tok_in.vld) begin
				case (tok_in.op)
					OP_ADD_PER: begin
						if (!tok_in.hit && !valid_q) begin
							period_q   <= tok_in.amt;
							next_due_q <= '0;
						end
					end
					OP_ADD_AT: begin
						if (!tok_in.hit && !valid_q) begin
							period_q   <= '0;
							next_due_q <= tok_in.amt;
						end
					end
					OP_CHG_PER: begin
						if (id_match && valid_q) period_q <= tok_in.amt;
					end
					OP_TICK: begin
						if (due) next_due_q <= tok_in.amt + period_q;
					end
					default: ;
				endcase
			end
		end
	end

endmodule

// File: design/periodic_task_scheduler_table_top.sv
// Periodic task scheduler table, top level: request intake, time scaling, cell chain, results.
// Depends on ptst_pkg and ptst_cell.
//
// The block keeps MAX_TASKS task slots, each one held by a cell in a chain. A request is taken
// only while the block is idle (req_stall is high from acceptance until the last result of the
// request has been loaded into the output register). The amount is registered, then multiplied
// by time_scale (low 32 bits kept) in a second stage. A tick whose scaled time equals the last
// tick time answers "none due" right there, without entering the chain. Every other operation
// sends a token down the chain, one cell per cycle while the chain advances: adds take the
// lowest free slot, delete and change-period act on the addressed slot, and a tick reschedules
// each due slot at now plus its period and reports it. The walk of the token through the chain
// sets how long a request takes; output stalls add to that whenever a due report or the final
// result cannot be handed over. Due reports come out in slot order; the last one is held back
// so it can carry last = 1. A request with an unknown operation is accepted and dropped with
// no result. time_scale resets to 1 and is written via cfg_we/cfg_data; the user must write
// it only while idle; the block does not enforce it. No clearing pass is needed after reset.
module periodic_task_scheduler_table_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  ptst_pkg::req_t               req,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output ptst_pkg::res_t               rsp,
	input  logic                         cfg_we,
	input  logic [ptst_pkg::SCALE_W-1:0] cfg_data
);
	import ptst_pkg::*;

	localparam int LAST = MAX_TASKS - 1;

	// config and tick history
	logic [SCALE_W-1:0] time_scale_q;
	logic [TIME_W-1:0]  last_tick_q;

	// intake pipeline
	logic               busy_q;
	logic               vld_s1;
	req_t               req_s1;
	logic               vld_s2;
	logic [OP_W-1:0]    op_s2;
	logic [TID_W-1:0]   id_s2;
	logic [TIME_W-1:0]  amt_s2;
	logic [AMT_W+SCALE_W-1:0] prod;

	// chain
	tok_t               inj_tok;
	tok_t               tok_in  [MAX_TASKS];
	tok_t               tok_out [MAX_TASKS];
	logic [MAX_TASKS-1:0] due_vec;
	logic [MAX_TASKS-1:0] tok_vld;
	logic [IDX_W-1:0]   due_id;
	logic               due_any;
	tok_t               end_tok;

	// due report holding and output
	logic               pend_vld_q;
	logic [IDX_W-1:0]   pend_id_q;
	logic [CNT_W-1:0]   rep_cnt_q;
	logic               out_vld_q;
	res_t               out_q;

	logic               accept;
	logic               op_known;
	logic               out_free;
	logic               rep_ok;
	logic               need_flush;
	logic               adv;
	logic               repeat_hit;
	logic               rep_emit;
	logic               inject;
	logic               fin;
	logic               load;
	res_t               load_res;
	res_t               fin_res;

	assign req_stall = busy_q;
	assign accept    = req_valid && !req_stall;
	assign op_known  = (req.operation == OP_ADD_PER) || (req.operation == OP_ADD_AT)
		|| (req.operation == OP_DELETE) || (req.operation == OP_CHG_PER)
		|| (req.operation == OP_TICK);

	assign rsp_valid = out_vld_q;
	assign rsp       = out_q;
	assign out_free  = !out_vld_q || !rsp_stall;

	assign prod = {{SCALE_W{1'b0}}, req_s1.amount} * {{AMT_W{1'b0}}, time_scale_q};

	// chain wiring; the head cell only acts when the chain advances
	always_comb begin
		inj_tok      = '0;
		inj_tok.vld  = vld_s2 && !repeat_hit;
		inj_tok.op   = op_s2;
		inj_tok.id   = id_s2;
		inj_tok.amt  = amt_s2;
	end

	genvar gi;
	generate
		for (gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				assign tok_in[gi] = inj_tok;
			end else begin : g_link
				assign tok_in[gi] = tok_out[gi-1];
			end
			assign tok_vld[gi] = tok_out[gi].vld;
			ptst_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.adv     (adv),
				.idx     (IDX_W'(gi)),
				.tok_in  (tok_in[gi]),
				.tok_out (tok_out[gi]),
				.due     (due_vec[gi])
			);
		end
	endgenerate

	assign end_tok = tok_out[LAST];

	// only one cell sees the token, so at most one due bit is set
	always_comb begin
		due_id = '0;
		for (int i = 0; i < MAX_TASKS; i++) begin
			if (due_vec[i]) due_id = due_id | IDX_W'(i);
		end
	end
	assign due_any = |due_vec;

	assign rep_ok     = (rep_cnt_q < CNT_W'(RESULT_LIMIT));
	assign need_flush = due_any && rep_ok && pend_vld_q;
	assign adv        = !(need_flush && !out_free) && !(end_tok.vld && !out_free);

	assign repeat_hit = vld_s2 && (op_s2 == OP_TICK) && (amt_s2 == last_tick_q);
	assign rep_emit   = repeat_hit && out_free;
	assign inject     = vld_s2 && !repeat_hit && adv;
	assign fin        = end_tok.vld && adv;

	// final result of a request leaving the chain
	always_comb begin
		fin_res      = '0;
		fin_res.last = 1'b1;
		case (end_tok.op)
			OP_ADD_PER, OP_ADD_AT: begin
				fin_res.task_id_res = end_tok.hit ? TID_W'(end_tok.slot) : '0;
				fin_res.status      = end_tok.hit ? ST_OK : ST_FULL;
			end
			OP_DELETE, OP_CHG_PER: begin
				fin_res.task_id_res = end_tok.id;
				fin_res.status      = end_tok.hit ? ST_OK : ST_NOT_FOUND;
			end
			default: begin
				fin_res.task_id_res = pend_vld_q ? TID_W'(pend_id_q) : '0;
				fin_res.status      = pend_vld_q ? ST_DUE : ST_NONE_DUE;
			end
		endcase
	end

	always_comb begin
		load     = 1'b0;
		load_res = '0;
		if (rep_emit) begin
			load                 = 1'b1;
			load_res.task_id_res = '0;
			load_res.status      = ST_NONE_DUE;
			load_res.last        = 1'b1;
		end else if (need_flush && adv) begin
			load                 = 1'b1;
			load_res.task_id_res = TID_W'(pend_id_q);
			load_res.status      = ST_DUE;
			load_res.last        = 1'b0;
		end else if (fin) begin
			load     = 1'b1;
			load_res = fin_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_scale_q <= SCALE_W'(1);
			last_tick_q  <= '0;
			busy_q       <= 1'b0;
			vld_s1       <= 1'b0;
			vld_s2       <= 1'b0;
			pend_vld_q   <= 1'b0;
			rep_cnt_q    <= '0;
			out_vld_q    <= 1'b0;
		end else begin
			if (cfg_we) time_scale_q <= cfg_data;

			if (accept && op_known) busy_q <= 1'b1;
			else if (rep_emit || fin) busy_q <= 1'b0;

			vld_s1 <= accept && op_known;

			if (vld_s1) vld_s2 <= 1'b1;
			else if (rep_emit || inject) vld_s2 <= 1'b0;

			if (inject && (op_s2 == OP_TICK)) last_tick_q <= amt_s2;

			if (fin) begin
				pend_vld_q <= 1'b0;
				rep_cnt_q  <= '0;
			end else if (adv && due_any && rep_ok) begin
				pend_vld_q <= 1'b1;
				rep_cnt_q  <= rep_cnt_q + CNT_W'(1);
			end

			if (load) out_vld_q <= 1'b1;
			else if (!rsp_stall) out_vld_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) req_s1 <= req;
		if (vld_s1) begin
			op_s2  <= req_s1.operation;
			id_s2  <= req_s1.task_id;
			amt_s2 <= prod[TIME_W-1:0];
		end
		if (adv && due_any && rep_ok && !fin) pend_id_q <= due_id;
		if (load) out_q <= load_res;
	end

`ifndef SYNTH
	// one request in flight: the token sits in exactly one place at most
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({tok_vld, vld_s1, vld_s2}))
		else $error("more than one request in flight");

	// an idle block holds no token in the chain
	assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (tok_vld == '0))
		else $error("token in chain while idle");

	// a held due report belongs to a tick that is still walking the chain
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> (busy_q && (tok_vld != '0)))
		else $error("due report held with no tick in flight");

	// the last result of a request frees the intake in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> !busy_q)
		else $error("intake still blocked after final result");
`endif

endmodule
